// File: sv/mvt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mvt_pkg;

  // Matrix geometry
  localparam int LANES       = 4;
  localparam int ROW_W       = 64;
  localparam int LANE_STRIDE = 16;

  // Coefficient format: Q3.12
  localparam int FRAC_BITS = 12;
  localparam logic [LANE_STRIDE-1:0] COEF_ONE = 16'h1000;

  // Configuration register map
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0 = 3'd0,
    REG_ROW1 = 3'd1,
    REG_ROW2 = 3'd2,
    REG_ROW3 = 3'd3
  } reg_idx_t;

  // Identity row: 1.0 in the lane on the diagonal
  function automatic logic [ROW_W-1:0] identity_row(input logic [1:0] lane);
    logic [ROW_W-1:0] r;
    r = ROW_W'(COEF_ONE) << (LANE_STRIDE * int'(lane));
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/mvt_lane.sv
`timescale 1ns / 1ps
`default_nettype none

// One matrix row against the vector: four products, then a rounded sum.
module mvt_lane import mvt_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int COEF_WIDTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic [ROW_W-1:0]                    row,
  input  wire logic [LANES-1:0][DATA_WIDTH-1:0]    vec,
  output logic signed [DATA_WIDTH+COEF_WIDTH+2-FRAC_BITS-1:0] rnd
);

  localparam int PROD_W = DATA_WIDTH + COEF_WIDTH;
  localparam int SUM_W  = PROD_W + 2;
  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) << (FRAC_BITS - 1);

  logic signed [PROD_W-1:0] prod_next [LANES];
  logic signed [PROD_W-1:0] prod      [LANES];
  logic signed [SUM_W-1:0]  sum_next;

  // Stage 1: one multiplier per column
  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      prod_next[j] = PROD_W'($signed(row[j*LANE_STRIDE +: COEF_WIDTH]))
                   * PROD_W'($signed(vec[j]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= prod_next;
    end
  end

  // Stage 2: exact sum plus half an LSB, then drop the fraction (floor)
  always_comb begin
    sum_next = RND_HALF;
    for (int j = 0; j < LANES; j++) begin
      sum_next = sum_next + SUM_W'(prod[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rnd <= sum_next[SUM_W-1:FRAC_BITS];
    end
  end

endmodule

`default_nettype wire

// File: sv/mvt_merge.sv
`timescale 1ns / 1ps
`default_nettype none

// Saturates the four lane sums and gathers the clip flag into the output register.
module mvt_merge import mvt_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int RND_W      = 38
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic signed [RND_W-1:0]      rnd [LANES],
  output logic        [DATA_WIDTH-1:0]      res [LANES],
  output logic                              clipped
);

  localparam int SAT_W = (RND_W > DATA_WIDTH) ? RND_W : DATA_WIDTH + 1;
  localparam logic signed [SAT_W-1:0] MAXV =
    {{(SAT_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [SAT_W-1:0] MINV = ~MAXV;

  logic signed [SAT_W-1:0]  ext      [LANES];
  logic [DATA_WIDTH-1:0]    res_next [LANES];
  logic                     clip_next;

  // Clamp each lane to the signed output range
  always_comb begin
    clip_next = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      ext[i] = SAT_W'(rnd[i]);
      priority if (ext[i] > MAXV) begin
        res_next[i] = MAXV[DATA_WIDTH-1:0];
        clip_next   = 1'b1;
      end else if (ext[i] < MINV) begin
        res_next[i] = MINV[DATA_WIDTH-1:0];
        clip_next   = 1'b1;
      end else begin
        res_next[i] = ext[i][DATA_WIDTH-1:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en) begin
      res     <= res_next;
      clipped <= clip_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/matrix_vector_transform_4x4_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Handshake                    | Payload
// ----------+------------------------------+----------------------------------------
// input     | in_valid / in_stall          | vec_x, vec_y, vec_z, vec_w (Q16.16)
// output    | out_valid / out_stall        | out_x, out_y, out_z, out_w, clipped
// config    | cfg_wr_en, cfg_index         | cfg_wdata (matrix rows 0..3)
//
// One transaction per cycle sustained while out_stall is low; each accepted item passes
// through the multiplier stage, adder stage and saturating output register, with
// the sixteen multipliers of the four row lanes working together.
// Reset loads the identity matrix and empties the pipeline.
// out_stall freezes the whole pipeline while out_valid is high; a one-entry skid
// register takes the item arriving in that cycle, and in_stall is high while it is occupied.
module matrix_vector_transform_4x4_unit import mvt_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int COEF_WIDTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ROW_W-1:0]      cfg_wdata,
  // input channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [DATA_WIDTH-1:0] vec_x,
  input  wire logic [DATA_WIDTH-1:0] vec_y,
  input  wire logic [DATA_WIDTH-1:0] vec_z,
  input  wire logic [DATA_WIDTH-1:0] vec_w,
  // output channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [DATA_WIDTH-1:0]      out_x,
  output logic [DATA_WIDTH-1:0]      out_y,
  output logic [DATA_WIDTH-1:0]      out_z,
  output logic [DATA_WIDTH-1:0]      out_w,
  output logic                       clipped
);

  localparam int RND_W = DATA_WIDTH + COEF_WIDTH + 2 - FRAC_BITS;

  logic [LANES-1:0][ROW_W-1:0]      rows;
  logic [LANES-1:0][DATA_WIDTH-1:0] in_vec;
  logic [LANES-1:0][DATA_WIDTH-1:0] skid_vec;
  logic [LANES-1:0][DATA_WIDTH-1:0] entry_vec;
  logic                             skid_valid;
  logic                             entry_valid;
  logic                             adv;
  logic                             s1_valid;
  logic                             s2_valid;
  logic signed [RND_W-1:0]          rnd [LANES];
  logic [DATA_WIDTH-1:0]            res [LANES];

  // Matrix row registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANES; i++) begin
        rows[i] <= identity_row(2'(i));
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ROW0: rows[0] <= cfg_wdata;
        REG_ROW1: rows[1] <= cfg_wdata;
        REG_ROW2: rows[2] <= cfg_wdata;
        REG_ROW3: rows[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline advances unless a finished result is held by the sink
  assign adv      = !out_valid || !out_stall;
  assign in_stall = skid_valid;
  assign in_vec   = {vec_w, vec_z, vec_y, vec_x};

  // Skid register ahead of the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (adv) begin
      skid_valid <= 1'b0;
    end else if (in_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!adv && in_valid && !skid_valid) begin
      skid_vec <= in_vec;
    end
  end

  assign entry_valid = skid_valid || in_valid;
  assign entry_vec   = skid_valid ? skid_vec : in_vec;

  // Valid tracking along the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= entry_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  // One lane per matrix row
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    mvt_lane #(
      .DATA_WIDTH (DATA_WIDTH),
      .COEF_WIDTH (COEF_WIDTH)
    ) u_lane (
      .clk (clk),
      .en  (adv),
      .row (rows[i]),
      .vec (entry_vec),
      .rnd (rnd[i])
    );
  end

  // Saturation and output register
  mvt_merge #(
    .DATA_WIDTH (DATA_WIDTH),
    .RND_W      (RND_W)
  ) u_merge (
    .clk     (clk),
    .en      (adv),
    .rnd     (rnd),
    .res     (res),
    .clipped (clipped)
  );

  assign out_x = res[0];
  assign out_y = res[1];
  assign out_z = res[2];
  assign out_w = res[3];

endmodule

`default_nettype wire
